// ===== design/priority_ceiling_resource_manager_top_assert.svh =====
// Assertion macros for the resource manager checks.
`ifndef PRIORITY_CEILING_RESOURCE_MANAGER_TOP_ASSERT_SVH
`define PRIORITY_CEILING_RESOURCE_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PCRM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcrm check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PCRM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcrm check failed");

`endif

// ===== design/pcrm_pkg.sv =====
package pcrm_pkg;

	localparam int NUM_RESOURCES = 8;
	localparam int NUM_TASKS     = 16;
	localparam int RID_W         = $clog2(NUM_RESOURCES);
	localparam int TID_W         = $clog2(NUM_TASKS);
	localparam int CEIL_N        = 8;
	localparam int CEIL_IW       = $clog2(CEIL_N);

	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_REL = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ID    = 2'd1,
		ST_REFUSED   = 2'd2,
		ST_NOT_OWNER = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RQ_NONE  = 2'd0,
		RQ_RAISE = 2'd1,
		RQ_LOWER = 2'd2
	} requeue_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

// ===== design/pcrm_if.sv =====
interface pcrm_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] resource_id;
	logic [3:0] task_id;
	logic [7:0] current_priority;

	modport source (output valid, cmd, resource_id, task_id, current_priority, input ready);
	modport sink (input valid, cmd, resource_id, task_id, current_priority, output ready);
endinterface

interface pcrm_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] new_priority;
	logic [7:0] old_priority;
	logic [1:0] requeue;
	logic       reschedule;

	modport source (output valid, status, new_priority, old_priority, requeue, reschedule,
		input ready);
	modport sink (input valid, status, new_priority, old_priority, requeue, reschedule,
		output ready);
endinterface

// ===== design/pcrm_datapath.sv =====
module pcrm_datapath import pcrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  dp_cmd_t     cmd,
	input  logic        in_cmd,
	input  logic [7:0]  in_resource_id,
	input  logic [3:0]  in_task_id,
	input  logic [7:0]  in_current_priority,
	output logic [1:0]  status,
	output logic [7:0]  new_priority,
	output logic [7:0]  old_priority,
	output logic [1:0]  requeue,
	output logic        reschedule
);

	logic [CEIL_N-1:0][7:0] ceil_q;

	logic                   owner_valid_q [NUM_RESOURCES];
	logic [3:0]             owner_task_q [NUM_RESOURCES];
	logic [7:0]             nesting_q [NUM_RESOURCES];
	logic [7:0]             saved_q [NUM_RESOURCES];
	logic [7:0]             held_q [NUM_TASKS];

	logic                   req_cmd_q;
	logic [7:0]             req_rid_q;
	logic [3:0]             req_tid_q;
	logic [7:0]             req_cur_q;

	logic [RID_W-1:0]       ri;
	logic [TID_W-1:0]       ti;
	logic                   id_ok;
	logic [7:0]             ceil;
	logic                   own_v;
	logic                   own_match;
	logic [7:0]             nest;
	logic [7:0]             held;
	status_t                st;
	requeue_t               rq;
	logic [7:0]             newp;
	logic                   resched;

	assign ri    = RID_W'(req_rid_q);
	assign ti    = TID_W'(req_tid_q);
	assign id_ok = (req_rid_q != 8'd0) && (req_rid_q < 8'(NUM_RESOURCES))
		&& (9'(req_tid_q) < 9'(NUM_TASKS));

	assign ceil      = ceil_q[CEIL_IW'(ri)];
	assign own_v     = owner_valid_q[ri];
	assign own_match = owner_task_q[ri] == req_tid_q;
	assign nest      = nesting_q[ri];
	assign held      = held_q[ti];

	always_comb begin
		st      = ST_OK;
		rq      = RQ_NONE;
		newp    = req_cur_q;
		resched = 1'b0;
		if (!id_ok) begin
			st = ST_BAD_ID;
		end else if (req_cmd_q == CMD_GET) begin
			if (own_v && !own_match) begin
				st = ST_REFUSED;
			end else if (nest == CNT_MAX || held == CNT_MAX) begin
				st = ST_REFUSED;
			end else if (ceil > req_cur_q) begin
				newp = ceil;
				rq   = RQ_RAISE;
			end
		end else begin
			if (!own_v || !own_match) begin
				st = ST_NOT_OWNER;
			end else if (nest == 8'd0 || held == 8'd0) begin
				st = ST_NOT_OWNER;
			end else begin
				resched = 1'b1;
				if (nest == 8'd1) begin
					newp = saved_q[ri];
					rq   = RQ_LOWER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q <= '0;
		end else if (cfg_we) begin
			ceil_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_cmd_q <= in_cmd;
			req_rid_q <= in_resource_id;
			req_tid_q <= in_task_id;
			req_cur_q <= in_current_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				owner_valid_q[i] <= 1'b0;
				owner_task_q[i]  <= '0;
				nesting_q[i]     <= '0;
				saved_q[i]       <= '0;
			end
			for (int j = 0; j < NUM_TASKS; j++) begin
				held_q[j] <= '0;
			end
		end else if (cmd.exec && st == ST_OK) begin
			if (req_cmd_q == CMD_GET) begin
				if (!own_v) begin
					saved_q[ri] <= req_cur_q;
				end
				owner_valid_q[ri] <= 1'b1;
				owner_task_q[ri]  <= req_tid_q;
				nesting_q[ri]     <= nest + 8'd1;
				held_q[ti]        <= held + 8'd1;
			end else begin
				nesting_q[ri] <= nest - 8'd1;
				held_q[ti]    <= held - 8'd1;
				if (nest == 8'd1) begin
					owner_valid_q[ri] <= 1'b0;
				end
			end
		end
	end

	// Hold the result word until the controller loads the next one.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status       <= st;
			new_priority <= newp;
			old_priority <= req_cur_q;
			requeue      <= rq;
			reschedule   <= resched;
		end
	end

endmodule

// ===== design/pcrm_ctrl.sv =====
module pcrm_ctrl import pcrm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) begin
					state_d = CS_EXEC;
				end
			end
			CS_EXEC: begin
				if (slot_free) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			CS_EXEC: begin
				cmd.exec = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/priority_ceiling_resource_manager_top.sv =====
// Priority ceiling resource manager: one get or release request in, one result word out.
// A request is captured in the cycle it is accepted; in the execute state the block then
// reads the owner, nesting, saved-priority and held-count tables, writes them back and
// loads the output register, waiting in that state while an earlier result is unaccepted.
// One request is in progress at a time; the next is taken in the cycle after the result is
// loaded, even while that result still waits on rsp.ready, so a new request is taken only
// once the last one is through. The user must write ceiling_table through cfg_we/cfg_wdata
// only while no request is in progress; the block does not enforce this. It resets to zero.
module priority_ceiling_resource_manager_top import pcrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	pcrm_req_if.sink    req,
	pcrm_rsp_if.source  rsp
);

	dp_cmd_t dp_cmd;

	pcrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (dp_cmd)
	);

	pcrm_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.cmd                 (dp_cmd),
		.in_cmd              (req.cmd),
		.in_resource_id      (req.resource_id),
		.in_task_id          (req.task_id),
		.in_current_priority (req.current_priority),
		.status              (rsp.status),
		.new_priority        (rsp.new_priority),
		.old_priority        (rsp.old_priority),
		.requeue             (rsp.requeue),
		.reschedule          (rsp.reschedule)
	);

endmodule

// ===== design/pcrm_checker.sv =====
`include "priority_ceiling_resource_manager_top_assert.svh"

module pcrm_checker import pcrm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [7:0] rsp_new_priority,
	input logic [7:0] rsp_old_priority,
	input logic [1:0] rsp_requeue,
	input logic       rsp_reschedule
);

	`PCRM_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_new_priority) && $stable(rsp_requeue))
	`PCRM_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)
	`PCRM_ASSERT_IMP(a_reject_quiet, rsp_valid && rsp_status != ST_OK, rsp_requeue == RQ_NONE && !rsp_reschedule && rsp_new_priority == rsp_old_priority)
	`PCRM_ASSERT_IMP(a_raise_up, rsp_valid && rsp_requeue == RQ_RAISE, rsp_new_priority > rsp_old_priority && !rsp_reschedule)
	`PCRM_ASSERT_IMP(a_lower_resched, rsp_valid && rsp_requeue == RQ_LOWER, rsp_reschedule && rsp_status == ST_OK)

endmodule

bind priority_ceiling_resource_manager_top pcrm_checker u_pcrm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_new_priority (rsp.new_priority),
	.rsp_old_priority (rsp.old_priority),
	.rsp_requeue      (rsp.requeue),
	.rsp_reschedule   (rsp.reschedule)
);
